>>> hdl/flvd_pkg.sv
`default_nettype none

package flvd_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] TAG_AUDIO = 8'd8;
  localparam logic [7:0] TAG_VIDEO = 8'd9;

  localparam logic [3:0] VCODEC_VP6    = 4'd4;
  localparam logic [3:0] VCODEC_VP6A   = 4'd5;
  localparam logic [3:0] VCODEC_AVC    = 4'd7;
  localparam logic [3:0] AFMT_AAC      = 4'd10;
  localparam logic [3:0] FRAME_KEY     = 4'd1;
  localparam logic [3:0] FRAME_COMMAND = 4'd5;

  localparam logic [7:0] PKT_TYPE_NALU = 8'd1;

  // header byte positions
  localparam logic [3:0] HIDX_TYPE    = 4'd4;
  localparam logic [3:0] HIDX_SIZE_HI = 4'd5;
  localparam logic [3:0] HIDX_SIZE_LO = 4'd7;
  localparam logic [3:0] HIDX_TS_HI   = 4'd8;
  localparam logic [3:0] HIDX_TS_LO   = 4'd10;
  localparam logic [3:0] HIDX_TS_EXT  = 4'd11;
  localparam logic [3:0] HIDX_LAST    = 4'd14;

  localparam logic [13:0] MS_TO_100NS = 14'd10000;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_FLAGS   = 5'b00010,
    PH_PREFIX  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_SKIP    = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       restart;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        is_video;
    logic [45:0] start_time;
    logic        sync_point;
    logic [23:0] packet_length;
    logic        first_of_packet;
    logic        last_of_packet;
  } out_word_t;

  // classified payload byte, time still in ms
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        is_video;
    logic [31:0] time_ms;
    logic        sync_point;
    logic [23:0] packet_length;
    logic        first_of_packet;
    logic        last_of_packet;
  } item_t;

endpackage

`default_nettype wire

>>> hdl/flvd_ifs.sv
`default_nettype none

interface flvd_in_if;
  logic               valid;
  logic               ready;
  flvd_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface flvd_out_if;
  logic                valid;
  logic                ready;
  flvd_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/flvd_front.sv
`default_nettype none

module flvd_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire flvd_pkg::in_word_t word_i,
  output logic                    ready_o,
  input  wire logic               full_i,
  output logic                    push_o,
  output flvd_pkg::item_t         item_o
);

  flvd_pkg::phase_e phase_q, phase_d, ph;
  logic [3:0]  hidx_q, hidx_d, hidx;
  logic [7:0]  tag_kind_q, tag_kind_d;
  logic [23:0] bytes_left_q, bytes_left_d, bl_dec;
  logic [31:0] time_q, time_d;
  logic [23:0] comp_q, comp_d;
  logic [3:0]  frame_q, frame_d;
  logic [3:0]  codec_q, codec_d, codec_new;
  logic [2:0]  pidx_q, pidx_d, pidx_inc;
  logic        first_q, first_d;
  logic [23:0] total_q, total_d;
  logic        accept, video, checks;
  logic [7:0]  b;

  function automatic logic [2:0] prefix_len(input logic vid, input logic [3:0] codec);
    logic [2:0] len;
    len = 3'd0;
    if (vid) begin
      if (codec == flvd_pkg::VCODEC_VP6) len = 3'd1;
      else if (codec == flvd_pkg::VCODEC_VP6A || codec == flvd_pkg::VCODEC_AVC) len = 3'd4;
    end else if (codec == flvd_pkg::AFMT_AAC) begin
      len = 3'd1;
    end
    return len;
  endfunction

  assign ready_o   = !full_i;
  assign accept    = valid_i && ready_o;
  assign b         = word_i.stream_byte;
  assign video     = (tag_kind_q == flvd_pkg::TAG_VIDEO);
  assign bl_dec    = bytes_left_q - 24'd1;
  assign pidx_inc  = pidx_q + 3'd1;
  assign codec_new = video ? b[3:0] : b[7:4];
  assign checks    = (video && codec_q == flvd_pkg::VCODEC_AVC) ||
                     (tag_kind_q == flvd_pkg::TAG_AUDIO && codec_q == flvd_pkg::AFMT_AAC);
  assign ph        = word_i.restart ? flvd_pkg::PH_HEADER : phase_q;
  assign hidx      = word_i.restart ? 4'd0 : hidx_q;

  always_comb begin
    item_o.payload_byte    = b;
    item_o.is_video        = video;
    item_o.time_ms         = time_q + {{8{comp_q[23]}}, comp_q};
    item_o.sync_point      = video ? (frame_q == flvd_pkg::FRAME_KEY) : 1'b1;
    item_o.packet_length   = total_q;
    item_o.first_of_packet = first_q;
    item_o.last_of_packet  = (bl_dec == 24'd0);
  end

  always_comb begin
    phase_d      = phase_q;
    hidx_d       = hidx_q;
    tag_kind_d   = tag_kind_q;
    bytes_left_d = bytes_left_q;
    time_d       = time_q;
    comp_d       = comp_q;
    frame_d      = frame_q;
    codec_d      = codec_q;
    pidx_d       = pidx_q;
    first_d      = first_q;
    total_d      = total_q;
    push_o       = 1'b0;
    if (accept) begin
      unique case (ph)
        flvd_pkg::PH_HEADER: begin
          if (hidx == flvd_pkg::HIDX_TYPE) begin
            tag_kind_d = b;
          end else if (hidx >= flvd_pkg::HIDX_SIZE_HI && hidx <= flvd_pkg::HIDX_SIZE_LO) begin
            bytes_left_d = {bytes_left_q[15:0], b};
          end else if (hidx >= flvd_pkg::HIDX_TS_HI && hidx <= flvd_pkg::HIDX_TS_LO) begin
            time_d = {8'd0, time_q[15:0], b};
          end else if (hidx == flvd_pkg::HIDX_TS_EXT) begin
            time_d = time_q | {b, 24'd0};
          end
          hidx_d  = hidx + 4'd1;
          phase_d = flvd_pkg::PH_HEADER;
          if (hidx == flvd_pkg::HIDX_LAST) begin
            hidx_d = 4'd0;
            comp_d = 24'd0;
            pidx_d = 3'd0;
            if (bytes_left_q == 24'd0) begin
              phase_d = flvd_pkg::PH_HEADER;
            end else if (tag_kind_q == flvd_pkg::TAG_AUDIO ||
                         tag_kind_q == flvd_pkg::TAG_VIDEO) begin
              phase_d = flvd_pkg::PH_FLAGS;
            end else begin
              phase_d = flvd_pkg::PH_SKIP;
            end
          end
        end
        flvd_pkg::PH_FLAGS: begin
          bytes_left_d = bl_dec;
          frame_d      = b[7:4];
          codec_d      = codec_new;
          if (bl_dec == 24'd0) begin
            phase_d = flvd_pkg::PH_HEADER;
            hidx_d  = 4'd0;
          end else if (video && b[7:4] == flvd_pkg::FRAME_COMMAND) begin
            phase_d = flvd_pkg::PH_SKIP;
          end else if (prefix_len(video, codec_new) != 3'd0) begin
            phase_d = flvd_pkg::PH_PREFIX;
            pidx_d  = 3'd0;
          end else begin
            phase_d = flvd_pkg::PH_PAYLOAD;
            total_d = bl_dec;
            first_d = 1'b1;
          end
        end
        flvd_pkg::PH_PREFIX: begin
          bytes_left_d = bl_dec;
          if (pidx_q == 3'd0 && checks && b != flvd_pkg::PKT_TYPE_NALU) begin
            if (bl_dec == 24'd0) begin
              phase_d = flvd_pkg::PH_HEADER;
              hidx_d  = 4'd0;
            end else begin
              phase_d = flvd_pkg::PH_SKIP;
            end
          end else begin
            if (pidx_q != 3'd0 && video && codec_q == flvd_pkg::VCODEC_AVC) begin
              comp_d = {comp_q[15:0], b};
            end
            pidx_d = pidx_inc;
            if (pidx_inc >= prefix_len(video, codec_q)) begin
              if (bl_dec == 24'd0) begin
                phase_d = flvd_pkg::PH_HEADER;
                hidx_d  = 4'd0;
              end else begin
                phase_d = flvd_pkg::PH_PAYLOAD;
                total_d = bl_dec;
                first_d = 1'b1;
              end
            end else if (bl_dec == 24'd0) begin
              phase_d = flvd_pkg::PH_HEADER;
              hidx_d  = 4'd0;
            end
          end
        end
        flvd_pkg::PH_PAYLOAD: begin
          push_o       = 1'b1;
          bytes_left_d = bl_dec;
          first_d      = 1'b0;
          if (bl_dec == 24'd0) begin
            phase_d = flvd_pkg::PH_HEADER;
            hidx_d  = 4'd0;
          end
        end
        flvd_pkg::PH_SKIP: begin
          if (bytes_left_q != 24'd0) bytes_left_d = bl_dec;
          if (bytes_left_q == 24'd0 || bl_dec == 24'd0) begin
            phase_d = flvd_pkg::PH_HEADER;
            hidx_d  = 4'd0;
          end
        end
        default: begin
          phase_d = flvd_pkg::PH_HEADER;
          hidx_d  = 4'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= flvd_pkg::PH_HEADER;
      hidx_q       <= 4'd0;
      tag_kind_q   <= 8'd0;
      bytes_left_q <= 24'd0;
      time_q       <= 32'd0;
      comp_q       <= 24'd0;
      frame_q      <= 4'd0;
      codec_q      <= 4'd0;
      pidx_q       <= 3'd0;
      first_q      <= 1'b1;
      total_q      <= 24'd0;
    end else begin
      phase_q      <= phase_d;
      hidx_q       <= hidx_d;
      tag_kind_q   <= tag_kind_d;
      bytes_left_q <= bytes_left_d;
      time_q       <= time_d;
      comp_q       <= comp_d;
      frame_q      <= frame_d;
      codec_q      <= codec_d;
      pidx_q       <= pidx_d;
      first_q      <= first_d;
      total_q      <= total_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/flvd_queue.sv
`default_nettype none

module flvd_queue #(
  parameter int Depth = flvd_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire flvd_pkg::item_t wdata_i,
  input  wire logic            pop_i,
  output flvd_pkg::item_t      rdata_o,
  output logic                 empty_o,
  output logic                 full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  flvd_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign empty_o = (cnt_q == CntW'(0));
  assign full_o  = (cnt_q == CntW'(Depth));
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

`default_nettype wire

>>> hdl/flvd_back.sv
`default_nettype none

module flvd_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            empty_i,
  input  wire flvd_pkg::item_t item_i,
  output logic                 pop_o,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output flvd_pkg::out_word_t  word_o
);

  logic                valid_q;
  flvd_pkg::out_word_t word_q;

  assign pop_o   = !empty_i && (!valid_q || ready_i);
  assign valid_o = valid_q;
  assign word_o  = word_q;

  // ms to 100 ns: 32 x 14 constant multiply, registered
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      word_q.payload_byte    <= item_i.payload_byte;
      word_q.is_video        <= item_i.is_video;
      word_q.start_time      <= 46'(item_i.time_ms) * 46'(flvd_pkg::MS_TO_100NS);
      word_q.sync_point      <= item_i.sync_point;
      word_q.packet_length   <= item_i.packet_length;
      word_q.first_of_packet <= item_i.first_of_packet;
      word_q.last_of_packet  <= item_i.last_of_packet;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> hdl/flv_tag_stream_demux.sv
// Channel    Dir  Word                          Payload
// stream_i   in   one FLV body byte             stream_byte, restart
// packet_o   out  one payload byte + metadata   payload_byte .. last_of_packet
//
// One body byte per clock while the queue is not full; a payload byte taken is
// written into the queue, then popped into the 100 ns multiply register on packet_o.
// Header, flags, prefix and skipped bytes give no word.
// Reset clears the parser to header collection and empties the queue.
// stream_i stalls only when the queue is full; packet_o back-pressure fills it.
`default_nettype none

module flv_tag_stream_demux #(
  parameter int QueueDepth = flvd_pkg::QUEUE_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  flvd_in_if.sink    stream_i,
  flvd_out_if.source packet_o
);

  logic            push, pop, empty, full;
  flvd_pkg::item_t wr_item, rd_item;

  flvd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stream_i.valid),
    .word_i  (stream_i.data),
    .ready_o (stream_i.ready),
    .full_i  (full),
    .push_o  (push),
    .item_o  (wr_item)
  );

  flvd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_item),
    .pop_i   (pop),
    .rdata_o (rd_item),
    .empty_o (empty),
    .full_o  (full)
  );

  flvd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .item_i  (rd_item),
    .pop_o   (pop),
    .valid_o (packet_o.valid),
    .ready_i (packet_o.ready),
    .word_o  (packet_o.data)
  );

endmodule

`default_nettype wire
